>>> src/gbn_pkg.sv
// Package for the greedy box NMS block: defaults, queue depth, result word
// and the state encoding of the back end. No dependencies.
`timescale 1ns / 1ps
package gbn_pkg;
	localparam int GBN_MAX_KEPT   = 64;
	localparam int GBN_COORD_BITS = 16;
	localparam int GBN_QDEPTH     = 2;
	localparam logic [15:0] GBN_THR_RESET = 16'd32768;

	typedef struct packed {
		logic       keep;
		logic [5:0] kept_slot;
		logic       store_full;
	} gbn_res_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} gbn_state_t;
endpackage

>>> src/gbn_box_if.sv
// Valid/ready channel carrying one candidate box word.
// No dependencies.
`timescale 1ns / 1ps
interface gbn_box_if;
	logic        valid;
	logic        ready;
	logic        first_of_set;
	logic [15:0] box_x;
	logic [15:0] box_y;
	logic [15:0] box_w;
	logic [15:0] box_h;
	modport source(output valid, first_of_set, box_x, box_y, box_w, box_h, input ready);
	modport sink(input valid, first_of_set, box_x, box_y, box_w, box_h, output ready);
endinterface

>>> src/gbn_res_if.sv
// Valid/ready channel carrying one suppression result word.
// No dependencies.
`timescale 1ns / 1ps
interface gbn_res_if;
	logic       valid;
	logic       ready;
	logic       keep;
	logic [5:0] kept_slot;
	logic       store_full;
	modport source(output valid, keep, kept_slot, store_full, input ready);
	modport sink(input valid, keep, kept_slot, store_full, output ready);
endinterface

>>> src/gbn_front.sv
// Front end: accepts boxes, masks coordinates, forms the far edges and area.
// Depends on gbn_pkg and gbn_box_if.
`timescale 1ns / 1ps
module gbn_front
	import gbn_pkg::*;
#(
	parameter int COORD_BITS = GBN_COORD_BITS,
	localparam int E  = COORD_BITS + 1,
	localparam int QW = 1 + 2 * COORD_BITS + 2 * E + 2 * COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	gbn_box_if.sink       box,
	output logic          push_valid,
	input  logic          push_ready,
	output logic [QW-1:0] push_data
);
	localparam int CB = COORD_BITS;

	logic          v_s1;
	logic          first_s1;
	logic [CB-1:0] x_s1, y_s1;
	logic [E-1:0]  x1_s1, y1_s1;
	logic [2*CB-1:0] area_s1;

	logic [39:0] xe, ye, we, he;
	logic [CB-1:0] xm, ym, wm, hm;

	assign xe = {24'b0, box.box_x};
	assign ye = {24'b0, box.box_y};
	assign we = {24'b0, box.box_w};
	assign he = {24'b0, box.box_h};
	assign xm = xe[CB-1:0];
	assign ym = ye[CB-1:0];
	assign wm = we[CB-1:0];
	assign hm = he[CB-1:0];

	assign box.ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (box.ready) begin
			v_s1 <= box.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (box.valid && box.ready) begin
			first_s1 <= box.first_of_set;
			x_s1     <= xm;
			y_s1     <= ym;
			x1_s1    <= {1'b0, xm} + {1'b0, wm};
			y1_s1    <= {1'b0, ym} + {1'b0, hm};
			area_s1  <= {{CB{1'b0}}, wm} * {{CB{1'b0}}, hm};
		end
	end

	assign push_valid = v_s1;
	assign push_data  = {first_s1, x_s1, y_s1, x1_s1, y1_s1, area_s1};
endmodule

>>> src/gbn_fifo.sv
// Short queue between the front and back ends.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_fifo
	import gbn_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam int PW = (GBN_QDEPTH > 1) ? $clog2(GBN_QDEPTH) : 1;
	localparam int CW = $clog2(GBN_QDEPTH + 1);

	logic [W-1:0]  mem_q [GBN_QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = cnt_q != CW'(GBN_QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(GBN_QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(GBN_QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end
endmodule

>>> src/gbn_back.sv
// Back end: compares a box against the kept store, one entry a cycle through
// a four-stage pipeline, then stores it when kept and the store has room, and issues the result word.
// Depends on gbn_pkg and gbn_res_if.
`timescale 1ns / 1ps
module gbn_back
	import gbn_pkg::*;
#(
	parameter int MAX_KEPT   = GBN_MAX_KEPT,
	parameter int COORD_BITS = GBN_COORD_BITS,
	localparam int E  = COORD_BITS + 1,
	localparam int QW = 1 + 2 * COORD_BITS + 2 * E + 2 * COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   thr,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  logic [QW-1:0] pop_data,
	gbn_res_if.source     res
);
	localparam int CB = COORD_BITS;
	localparam int A  = 2 * CB;
	localparam int P  = 2 * E;
	localparam int MW = QW - 1;
	localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = $clog2(MAX_KEPT + 1);

	gbn_state_t state_q;
	logic [CW-1:0] count_q, n_q, j_q;
	logic          keep_q;
	logic [MW-1:0] cur_q;
	logic [MW-1:0] mem_q [MAX_KEPT];

	logic          v_s1, v_s2, v_s3, v_s4;
	logic [MW-1:0] rd_s1;
	logic [E-1:0]  iw_s2, ih_s2;
	logic [A-1:0]  ka_s2, ka_s3;
	logic [P-1:0]  inter_s3, lhs_s4;
	logic [P+15:0] prod_s4;
	logic          nz_s4;
	gbn_res_t      res_q;
	logic          res_valid_q;

	logic [CB-1:0] cx, cy, kx, ky;
	logic [E-1:0]  cx1, cy1, kx1, ky1;
	logic [A-1:0]  ca, ka;
	logic [E-1:0]  lox, hix, loy, hiy;
	logic [P-1:0]  uni;
	logic          issue, done, fin, store, sup, start, first_in;
	logic [CW-1:0] n_new;
	logic [CW+5:0] slot_ext;

	assign {cx, cy, cx1, cy1, ca} = cur_q;
	assign {kx, ky, kx1, ky1, ka} = rd_s1;
	assign first_in = pop_data[QW-1];

	assign pop_ready = state_q == ST_IDLE;
	assign start     = pop_valid && pop_ready;
	assign n_new     = first_in ? '0 : count_q;
	assign issue     = state_q == ST_RUN && j_q < n_q;
	assign done      = state_q == ST_RUN && j_q == n_q && !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign fin       = done && (!res_valid_q || res.ready);
	assign store     = keep_q && count_q < CW'(MAX_KEPT);
	assign slot_ext  = {6'b0, count_q};

	// Overlap of the half-open spans on each axis; zero when they do not meet.
	assign lox = ({1'b0, cx} > {1'b0, kx}) ? {1'b0, cx} : {1'b0, kx};
	assign loy = ({1'b0, cy} > {1'b0, ky}) ? {1'b0, cy} : {1'b0, ky};
	assign hix = (cx1 < kx1) ? cx1 : kx1;
	assign hiy = (cy1 < ky1) ? cy1 : ky1;
	assign uni = P'(ca) + P'(ka_s3) - inter_s3;
	assign sup = v_s4 && nz_s4 && ({lhs_s4, 16'b0} > prod_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			n_q         <= '0;
			j_q         <= '0;
			keep_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (issue) begin
				j_q <= j_q + 1'b1;
			end
			if (sup) begin
				keep_q <= 1'b0;
			end
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						count_q <= n_new;
						n_q     <= n_new;
						j_q     <= '0;
						keep_q  <= 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (fin) begin
						if (store) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= pop_data[MW-1:0];
		end
		if (issue) begin
			rd_s1 <= mem_q[j_q[IW-1:0]];
		end
		if (fin && store) begin
			mem_q[count_q[IW-1:0]] <= cur_q;
		end
		if (fin) begin
			res_q.keep       <= keep_q;
			res_q.kept_slot  <= store ? slot_ext[5:0] : 6'd0;
			res_q.store_full <= keep_q && !store;
		end
		iw_s2    <= (hix > lox) ? hix - lox : '0;
		ih_s2    <= (hiy > loy) ? hiy - loy : '0;
		ka_s2    <= ka;
		inter_s3 <= {{E{1'b0}}, iw_s2} * {{E{1'b0}}, ih_s2};
		ka_s3    <= ka_s2;
		lhs_s4   <= inter_s3;
		nz_s4    <= uni != '0;
		prod_s4  <= {{P{1'b0}}, thr} * {16'b0, uni};
	end

	assign res.valid      = res_valid_q;
	assign res.keep       = res_q.keep;
	assign res.kept_slot  = res_q.kept_slot;
	assign res.store_full = res_q.store_full;

`ifndef ASSERT_OFF
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEPT)) else $error("kept count beyond store depth");
	a_full_keep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.store_full |-> res_q.keep) else $error("full flag on suppressed box");
	a_slot_keep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kept_slot != 6'd0 |-> res_q.keep && !res_q.store_full)
		else $error("slot given to a box not stored");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !pop_ready) else $error("queue popped while comparing");
`endif
endmodule

>>> src/greedy_box_nms_top.sv
// Greedy box NMS top level: front end, queue, back end and threshold register.
// Depends on gbn_pkg, gbn_box_if, gbn_res_if, gbn_front, gbn_fifo, gbn_back.
`timescale 1ns / 1ps
// With no stalls, a box word passes the front-end register and the queue, then
// the back end reads the kept store through its single read port one entry a
// cycle, one entry for each of the n boxes kept so far in the set (at most
// MAX_KEPT, none when the set is empty); the overlap, product and compare
// pipeline and the final decision register follow before the result shows.
// The back end handles one box at a time and takes no new box until it has
// issued the result word for the last one; a result word not yet taken holds
// the back end. Meanwhile the front end and a two-word queue take up to three
// further boxes. The kept store needs no clearing after reset.
module greedy_box_nms_top
	import gbn_pkg::*;
#(
	parameter int MAX_KEPT   = GBN_MAX_KEPT,
	parameter int COORD_BITS = GBN_COORD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	gbn_box_if.sink     box,
	gbn_res_if.source   res
);
	localparam int E  = COORD_BITS + 1;
	localparam int QW = 1 + 2 * COORD_BITS + 2 * E + 2 * COORD_BITS;

	logic [15:0]   thr_q;
	logic          f_valid, f_ready, b_valid, b_ready;
	logic [QW-1:0] f_data, b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= GBN_THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	gbn_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .box(box),
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_data)
	);

	gbn_fifo #(.W(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
	);

	gbn_back #(.MAX_KEPT(MAX_KEPT), .COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .thr(thr_q),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data), .res(res)
	);
endmodule

>>> dv/gbn_nms_checker.sv
// Checker for the greedy box NMS block: watches the box and result channels,
// keeps its own copy of the kept store and compares every result word.
// Depends on gbn_pkg, gbn_box_if and gbn_res_if.
`timescale 1ns / 1ps
module gbn_nms_checker
	import gbn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	gbn_box_if          box,
	gbn_res_if          res,
	output int unsigned fails,
	output int unsigned awaited,
	output int unsigned kept_seen,
	output int unsigned suppressed_seen,
	output int unsigned full_seen
);
	logic [15:0] iou_thr;
	logic [15:0] store_x [GBN_MAX_KEPT];
	logic [15:0] store_y [GBN_MAX_KEPT];
	logic [15:0] store_w [GBN_MAX_KEPT];
	logic [15:0] store_h [GBN_MAX_KEPT];
	logic [31:0] store_area [GBN_MAX_KEPT];
	int unsigned stored_boxes;
	gbn_res_t    verdict_q[$];

	task automatic report(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	// Works out the verdict for one box and updates the kept store as the block would.
	function automatic gbn_res_t judge_box(input logic first, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] w, input logic [15:0] h);
		logic [63:0] bx, by, bw, bh, area, lo, hi, iw, ih, inter, uni;
		gbn_res_t r;
		bx = x; by = y; bw = w; bh = h;
		area = bw * bh;
		r = '0;
		r.keep = 1'b1;
		if (first)
			stored_boxes = 0;
		for (int j = 0; j < stored_boxes; j++) begin
			lo = (bx > store_x[j]) ? bx : 64'(store_x[j]);
			hi = (bx + bw < 64'(store_x[j]) + store_w[j]) ? bx + bw : 64'(store_x[j]) + store_w[j];
			iw = (hi > lo) ? hi - lo : 64'd0;
			lo = (by > store_y[j]) ? by : 64'(store_y[j]);
			hi = (by + bh < 64'(store_y[j]) + store_h[j]) ? by + bh : 64'(store_y[j]) + store_h[j];
			ih = (hi > lo) ? hi - lo : 64'd0;
			inter = iw * ih;
			uni = area + store_area[j] - inter;
			// Intersection over union against the threshold, with the division
			// turned into a multiply on both sides.
			if (uni != 0 && (inter << 16) > 64'(iou_thr) * uni)
				r.keep = 1'b0;
		end
		if (r.keep) begin
			if (stored_boxes < GBN_MAX_KEPT) begin
				store_x[stored_boxes] = x;
				store_y[stored_boxes] = y;
				store_w[stored_boxes] = w;
				store_h[stored_boxes] = h;
				store_area[stored_boxes] = area[31:0];
				r.kept_slot = 6'(stored_boxes);
				stored_boxes++;
			end else begin
				r.store_full = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gbn_res_t want;
		if (!arst_n) begin
			iou_thr <= GBN_THR_RESET;
			stored_boxes = 0;
			verdict_q.delete();
			fails = 0;
			awaited = 0;
			kept_seen = 0;
			suppressed_seen = 0;
			full_seen = 0;
		end else begin
			if (cfg_we)
				iou_thr <= cfg_wdata;
			if (box.valid && box.ready)
				verdict_q = {verdict_q, judge_box(box.first_of_set, box.box_x, box.box_y,
					box.box_w, box.box_h)};
			if (res.valid && res.ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t result word with no box waiting for it", $realtime);
					fails++;
				end else begin
					want = verdict_q.pop_front();
					if (res.keep !== want.keep)
						report("keep", res.keep, want.keep);
					if (res.kept_slot !== want.kept_slot)
						report("kept_slot", res.kept_slot, want.kept_slot);
					if (res.store_full !== want.store_full)
						report("store_full", res.store_full, want.store_full);
					if (want.store_full)
						full_seen++;
					else if (want.keep)
						kept_seen++;
					else
						suppressed_seen++;
				end
			end
			awaited = verdict_q.size();
		end
	end
endmodule

>>> dv/tb_greedy_box_nms_top.sv
// Testbench top for greedy_box_nms_top: clock, reset, box stimulus, result
// back-pressure, threshold phases and the verdict. Depends on gbn_pkg, the
// channel interfaces, the block and gbn_nms_checker.
`timescale 1ns / 1ps
module tb_greedy_box_nms_top;
	import gbn_pkg::*;

	localparam int DRAIN_CYCLES = GBN_MAX_KEPT + 20;
	localparam int STALL_LIMIT  = 5000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int unsigned fails, awaited, kept_seen, suppressed_seen, full_seen;
	int unsigned boxes_sent;
	int unsigned set_left;
	bit          calm;
	bit          hold_req;
	int unsigned idle_cycles;

	gbn_box_if box_ch();
	gbn_res_if res_ch();

	greedy_box_nms_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.box(box_ch), .res(res_ch)
	);

	gbn_nms_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.box(box_ch), .res(res_ch), .fails(fails), .awaited(awaited),
		.kept_seen(kept_seen), .suppressed_seen(suppressed_seen), .full_seen(full_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: random stalls, and one long hold-off on request so the
	// queue fills and the box channel stalls.
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else if (calm) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= (gap_len() == 0);
			end
		end
	end

	// Watchdog: cycles in which neither channel moves a word.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else if (++idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("[greedy_box_nms_top] ERROR");
				$finish;
			end
		end
	end

	task automatic send_box(input logic first, input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] w, input logic [15:0] h);
		int unsigned gap;
		gap = gap_len();
		if (gap > 0) begin
			box_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		box_ch.valid <= 1'b1;
		box_ch.first_of_set <= first;
		box_ch.box_x <= x;
		box_ch.box_y <= y;
		box_ch.box_w <= w;
		box_ch.box_h <= h;
		forever begin
			@(posedge clk);
			if (box_ch.ready)
				break;
		end
		boxes_sent++;
	endtask

	task automatic drain_and_set(input logic [15:0] thr);
		box_ch.valid <= 1'b0;
		@(posedge clk);
		wait (awaited == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly clustered boxes so that overlaps are common, with some fully
	// random words and some at the edges of the coordinate range.
	task automatic random_box();
		logic        first;
		logic [15:0] x, y, w, h;
		int unsigned r;
		first = 1'b0;
		if (set_left == 0) begin
			first = 1'b1;
			set_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20)
				: $urandom_range(60, 90);
		end
		set_left--;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			x = 16'($urandom_range(1000, 3000));
			y = 16'($urandom_range(1000, 3000));
			w = 16'($urandom_range(0, 2500));
			h = 16'($urandom_range(0, 2500));
		end else if (r < 92) begin
			x = 16'($urandom);
			y = 16'($urandom);
			w = 16'($urandom);
			h = 16'($urandom);
		end else begin
			x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			w = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
			h = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
		end
		send_box(first, x, y, w, h);
	endtask

	initial begin
		logic [15:0] thr_plan [9];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		box_ch.valid = 1'b0;
		box_ch.first_of_set = 1'b0;
		box_ch.box_x = '0;
		box_ch.box_y = '0;
		box_ch.box_w = '0;
		box_ch.box_h = '0;
		boxes_sent = 0;
		set_left = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		thr_plan = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'($urandom), 16'($urandom),
			16'd6554, 16'($urandom), GBN_THR_RESET};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset threshold of one half.
		send_box(1'b1, 16'd0, 16'd0, 16'd100, 16'd100);
		send_box(1'b0, 16'd0, 16'd0, 16'd100, 16'd100);    // identical, suppressed
		send_box(1'b0, 16'd100, 16'd0, 16'd100, 16'd100);  // touching edge
		send_box(1'b0, 16'd10, 16'd10, 16'd100, 16'd100);  // heavy overlap
		send_box(1'b0, 16'd50, 16'd0, 16'd100, 16'd100);   // a third overlap
		send_box(1'b0, 16'd500, 16'd500, 16'd0, 16'd0);    // zero area
		send_box(1'b0, 16'd500, 16'd500, 16'd0, 16'd0);    // zero union pair
		send_box(1'b0, 16'd500, 16'd500, 16'd0, 16'd40);
		send_box(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_box(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_box(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_box(1'b1, 16'd0, 16'd0, 16'd100, 16'd100);    // new set, store cleared
		send_box(1'b0, 16'd0, 16'd0, 16'd100, 16'd100);

		// Disjoint boxes past the store size to reach the full store.
		drain_and_set(16'hFFFF);
		for (int i = 0; i < 68; i++)
			send_box(i == 0, 16'(i * 200), 16'd0, 16'd100, 16'd100);

		for (int p = 0; p < 9; p++) begin
			drain_and_set(thr_plan[p]);
			for (int i = 0; i < 128; i++) begin
				if (i % 64 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if (p == 1 && i == 10)
					hold_req = 1'b1;
				random_box();
			end
		end

		box_ch.valid <= 1'b0;
		wait (awaited == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d boxes sent over eleven threshold phases: %0d stored, %0d suppressed,",
			boxes_sent, kept_seen, suppressed_seen);
		$display("%0d kept with the store full; %0d mismatches.", full_seen, fails);
		if (fails == 0)
			$display("[greedy_box_nms_top] OK");
		else
			$display("[greedy_box_nms_top] ERROR");
		$finish;
	end
endmodule

>>> files.f
src/gbn_pkg.sv
src/gbn_box_if.sv
src/gbn_res_if.sv
src/gbn_front.sv
src/gbn_fifo.sv
src/gbn_back.sv
src/greedy_box_nms_top.sv
dv/gbn_nms_checker.sv
dv/tb_greedy_box_nms_top.sv
